/* hw/rtl/prvd_pkg.sv */
// Shared types and constants for the partial-response Viterbi detector.
// Used by every module under hw/rtl; depends on nothing.
package prvd_pkg;

    localparam int NUM_STATES      = 4;
    localparam int NUM_LEVELS      = 8;
    localparam int LEVEL_IDX_W     = 3;
    localparam int CFG_INDEX_W     = 4;
    localparam int LEVEL_W         = 8;
    localparam int SAMPLE_W        = 10;
    localparam int DIFF_W          = 11;
    localparam int BM_W            = 19;
    localparam int METRIC_W        = 24;
    localparam int TRACEBACK_DEPTH_DEF = 5;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

    typedef logic [METRIC_W-1:0]           t_metric;
    typedef logic [BM_W-1:0]               t_bm;
    typedef t_bm [NUM_LEVELS-1:0]          t_bm_set;
    typedef logic signed [LEVEL_W-1:0]     t_level;

    localparam t_metric METRIC_MAX = {METRIC_W{1'b1}};

    // levels indexed as bit*4 + state
    localparam t_level LEVEL_RESET [NUM_LEVELS] = '{
        -8'sd64, 8'sd0, -8'sd32, 8'sd32, -8'sd32, 8'sd32, 8'sd0, 8'sd64
    };

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

    typedef struct packed {
        logic warm_done;
        logic metric_zero;
    } t_back_stat;

endpackage

/* hw/rtl/partial_response_viterbi_detector_core.sv */
// Top level of the four-state partial-response Viterbi detector.
// Instantiates prvd_front, prvd_queue and prvd_back; depends on prvd_pkg.
//
// Usage:
//   Samples (signed Q5.5) enter on the i_in_valid / o_in_ready channel, one
//   word per cycle while o_in_ready is high, and get their eight branch
//   metrics in the front end and wait in a two-entry queue; the back end runs
//   add-compare-select on one queued word per cycle unless the receiver
//   stalls, giving one sample per clock, set by the ACS and normalisation loop.
//   The first TRACEBACK_DEPTH samples give no result; every later sample gives
//   one decided bit on o_out_valid / i_out_ready, the bit from TRACEBACK_DEPTH
//   samples earlier. When nothing stalls, an accepted sample is written to
//   the queue, popped by the back end, and the bit decided on it registered.
//   The eight branch levels are written through i_cfg_valid / i_cfg_index /
//   i_cfg_data (always ready); indexes beyond seven are ignored. Write them
//   only while the detector is idle.
//   Reset (synchronous, active low) clears metrics, survivors, warm-up count,
//   queue and output valid flag, and restores the default levels.
//   When the receiver stalls, the output register holds its word, the back
//   end stops, the queue fills and o_in_ready drops once both queue entries
//   hold a word, at most two samples later.
module partial_response_viterbi_detector_core
    import prvd_pkg::*;
#(
    parameter int TRACEBACK_DEPTH = TRACEBACK_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [LEVEL_W-1:0]         i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_decoded_bit
);

    t_bm_set     front_bm;
    t_bm_set     queue_bm;
    logic        queue_valid;
    logic        back_pop;
    logic        in_push;
    t_queue_stat queue_stat;
    t_back_stat  back_stat;

    assign o_in_ready = !queue_stat.full;
    assign in_push    = i_in_valid && o_in_ready;

    prvd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .o_bm        (front_bm)
    );

    prvd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_push),
        .i_push_data (front_bm),
        .i_pop       (back_pop),
        .o_pop_data  (queue_bm),
        .o_valid     (queue_valid),
        .o_stat      (queue_stat)
    );

    prvd_back #(
        .TRACEBACK_DEPTH (TRACEBACK_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bm_valid    (queue_valid),
        .i_bm          (queue_bm),
        .o_bm_pop      (back_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_decoded_bit (o_decoded_bit),
        .o_stat        (back_stat)
    );

    // an accepted sample is always waiting or in the back end next cycle
    a_push_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_push |=> !queue_stat.empty)
        else $error("queue empty after accepting a sample");

    a_no_result_in_warmup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> back_stat.warm_done)
        else $error("result offered before warm-up finished");

    a_metrics_normalised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.metric_zero)
        else $error("no path metric is zero after normalisation");

endmodule

/* hw/rtl/prvd_front.sv */
// Front end: level registers and branch metrics for one sample.
// Depends on prvd_pkg.
module prvd_front
    import prvd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [LEVEL_W-1:0]        i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output t_bm_set                   o_bm
);

    t_level r_level [NUM_LEVELS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LEVEL_RESET;
        end else if (i_cfg_valid && (i_cfg_index < CFG_INDEX_W'(NUM_LEVELS))) begin
            r_level[i_cfg_index[LEVEL_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // squared distance from each branch level, exact
    always_comb begin
        logic signed [DIFF_W-1:0]   diff;
        logic signed [2*DIFF_W-1:0] sq;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            diff    = DIFF_W'(i_sample) - DIFF_W'(r_level[i]);
            sq      = diff * diff;
            o_bm[i] = sq[BM_W-1:0];
        end
    end

endmodule

/* hw/rtl/prvd_queue.sv */
// Short queue of branch-metric words between front and back.
// Depends on prvd_pkg.
module prvd_queue
    import prvd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_bm_set     i_push_data,
    input  logic        i_pop,
    output t_bm_set     o_pop_data,
    output logic        o_valid,
    output t_queue_stat o_stat
);

    t_bm_set               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid      = !o_stat.empty;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/prvd_back.sv */
// Back end: add-compare-select, metric normalisation, register-exchange
// survivors and the output register. Depends on prvd_pkg.
module prvd_back
    import prvd_pkg::*;
#(
    parameter int TRACEBACK_DEPTH = TRACEBACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_bm_valid,
    input  t_bm_set    i_bm,
    output logic       o_bm_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_decoded_bit,
    output t_back_stat o_stat
);

    localparam int CW = $clog2(TRACEBACK_DEPTH + 1);

    t_metric                    r_pm   [NUM_STATES];
    t_metric                    n_pm   [NUM_STATES];
    logic [TRACEBACK_DEPTH-1:0] r_hist [NUM_STATES];
    logic [TRACEBACK_DEPTH-1:0] n_hist [NUM_STATES];
    logic [CW-1:0]              r_warm;
    logic [CW-1:0]              n_warm;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic                       r_out_bit;
    logic                       n_out_bit;

    t_metric    nm       [NUM_STATES];
    logic [1:0] sel_pred [NUM_STATES];
    t_metric    lo;
    logic [1:0] best;
    logic       steady;
    logic       fire;
    logic       dec_bit;

    assign steady   = (r_warm == CW'(TRACEBACK_DEPTH));
    assign fire     = i_bm_valid && (!r_out_valid || i_out_ready);
    assign o_bm_pop = fire;

    // add-compare-select; ties keep the lower-numbered predecessor
    always_comb begin
        logic [METRIC_W:0] sum;
        t_metric           cand [2];
        logic [1:0]        pred [2];
        for (int w = 0; w < NUM_STATES; w++) begin
            for (int k = 0; k < 2; k++) begin
                pred[k] = 2'(2 * k + (w >> 1));
                sum     = {1'b0, r_pm[pred[k]]}
                          + (METRIC_W + 1)'(i_bm[3'((w & 1) * 4) + 3'(pred[k])]);
                cand[k] = sum[METRIC_W] ? METRIC_MAX : sum[METRIC_W-1:0];
            end
            if (cand[1] < cand[0]) begin
                nm[w]       = cand[1];
                sel_pred[w] = pred[1];
            end else begin
                nm[w]       = cand[0];
                sel_pred[w] = pred[0];
            end
        end
    end

    // best state, lowest index on ties
    always_comb begin
        lo   = nm[0];
        best = '0;
        for (int w = 1; w < NUM_STATES; w++) begin
            if (nm[w] < lo) begin
                lo   = nm[w];
                best = 2'(w);
            end
        end
    end

    assign dec_bit = r_hist[sel_pred[best]][0];

    always_comb begin
        logic [TRACEBACK_DEPTH-1:0] ph;
        logic                       wbit;
        for (int w = 0; w < NUM_STATES; w++) begin
            ph      = r_hist[sel_pred[w]];
            wbit    = 1'(w & 1);
            n_pm[w] = nm[w] - lo;
            if (steady) begin
                // drop the oldest decision, append the newest
                n_hist[w] = {wbit, ph[TRACEBACK_DEPTH-1:1]};
            end else begin
                for (int j = 0; j < TRACEBACK_DEPTH; j++) begin
                    n_hist[w][j] = (CW'(j) == r_warm) ? wbit : ph[j];
                end
            end
        end
        n_warm = steady ? r_warm : r_warm + 1'b1;
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_bit   = r_out_bit;
        if (fire && steady) begin
            n_out_valid = 1'b1;
            n_out_bit   = dec_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_STATES; w++) begin
                r_pm[w]   <= '0;
                r_hist[w] <= '0;
            end
            r_warm      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_pm   <= n_pm;
                r_hist <= n_hist;
                r_warm <= n_warm;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_bit <= n_out_bit;
    end

    assign o_out_valid        = r_out_valid;
    assign o_decoded_bit      = r_out_bit;
    assign o_stat.warm_done   = steady;
    assign o_stat.metric_zero = (r_pm[0] == '0) || (r_pm[1] == '0)
                                || (r_pm[2] == '0) || (r_pm[3] == '0);

endmodule
